@@ rtl/dcfd_pkg.sv @@
// Shared types, constants and codes for the delimited command framer and decoder.
// Depends on nothing; the top level, framer, decoder and testbench import it.

package dcfd_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam int PAYLOAD_BYTES_DEF = 32;

	// Only the first seven little-endian words of a frame are ever decoded.
	localparam int NUM_WORDS = 7;
	localparam int WORD_IDX_W = 3;
	localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

	// Two banks of seven words: one frame fills a bank while the other is decoded.
	localparam int RAM_DEPTH = 2 * NUM_WORDS;
	localparam int RAM_AW = $clog2(RAM_DEPTH);

	localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd60;
	localparam logic [BYTE_W-1:0] END_CHAR_RST = 8'd62;
	localparam logic [1:0] DELIM_COUNT_RST = 2'd3;

	// Checksum remainder: floor(n / 123) = (n * RECIP) >> 38, exact for n up to 2**31.
	localparam int CHECK_MODULUS = 123;
	localparam int RECIP_SHIFT = 38;
	localparam logic [WORD_W-1:0] CHECK_RECIP =
		WORD_W'(((64'd1 << RECIP_SHIFT) + 64'(CHECK_MODULUS) - 64'd1) / 64'(CHECK_MODULUS));
	localparam int QUOT_W = 2 * WORD_W - RECIP_SHIFT;
	localparam int REM_W = 8;
	localparam int SUM_W = 11;

	localparam logic [WORD_W-1:0] CMD_ADD_POSITION = 32'd4;
	localparam logic [WORD_W-1:0] CMD_FIRST = 32'd1;
	localparam logic [WORD_W-1:0] CMD_LAST = 32'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_CHAR = 2'd0,
		REG_END_CHAR = 2'd1,
		REG_DELIM_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		FR_HUNT,
		FR_FRAME
	} fr_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_DONE
	} dec_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_char;
		logic [BYTE_W-1:0] end_char;
		logic [1:0] delim_count;
	} cfg_t;

	// A closed frame handed from the framer to the decoder.
	typedef struct packed {
		logic valid;
		logic bank;
		logic [WORD_IDX_W-1:0] full_words;
		logic [WORD_W-1:0] partial;
		logic overflow;
	} job_t;

	typedef struct packed {
		logic en;
		logic [RAM_AW-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

endpackage

@@ rtl/dcfd_byte_if.sv @@
// Byte channel interface: valid, ready and one received serial byte.
// Depends on nothing.

interface dcfd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/dcfd_result_if.sv @@
// Result channel interface: valid, ready and one decoded command.
// Depends on nothing.

interface dcfd_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] command_word;
	logic recognized;
	logic accepted;
	logic signed [31:0] word_a;
	logic signed [31:0] word_b;
	logic signed [31:0] word_c;
	logic signed [31:0] word_d;
	logic signed [31:0] word_e;
	logic signed [31:0] word_f;
	logic overflowed;

	modport source (
		output valid, output command_word, output recognized, output accepted,
		output word_a, output word_b, output word_c, output word_d, output word_e,
		output word_f, output overflowed, input ready
	);
	modport sink (
		input valid, input command_word, input recognized, input accepted,
		input word_a, input word_b, input word_c, input word_d, input word_e,
		input word_f, input overflowed, output ready
	);
endinterface

@@ rtl/delimited_command_framer_decoder_core.sv @@
// Top level of the delimited command framer and decoder: configuration registers,
// framer, two-bank payload RAM and decoder. Depends on dcfd_pkg, both interfaces and all modules.
//
//   Channel   Direction  Carries
//   serial    sink       one received byte (in_byte) per transaction
//   command   source     one decoded command: seven words, three flags
//   cfg_*     write      start_char, end_char, delimiter_count by register index
//
// The block takes one byte every cycle, except a closing end character that is held off as below.
// After the closing end character, the decoder reads the frame's seven words from the payload
// RAM, passes each through the three stages of the remainder pipeline and then loads the
// output register. Reset clears all control state at once; the RAM needs no clearing pass.
// A closing end character is held off only while the decoder still works on the previous
// frame, including any time that frame's finished result waits for the output register.

module delimited_command_framer_decoder_core #(
	parameter int PAYLOAD_BYTES = dcfd_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dcfd_byte_if.sink                         serial,
	dcfd_result_if.source                     command,
	input  logic                              cfg_wr_en,
	input  logic [dcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import dcfd_pkg::*;

	cfg_t cfg_q;
	job_t job;
	logic job_ready;
	ram_wr_t ram_wr;
	logic ram_rd_en;
	logic [RAM_AW-1:0] ram_rd_addr;
	logic [WORD_W-1:0] ram_rd_data;

	// Configuration registers. Writes to an index beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char <= START_CHAR_RST;
			cfg_q.end_char <= END_CHAR_RST;
			cfg_q.delim_count <= DELIM_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_CHAR: cfg_q.start_char <= cfg_wdata;
				REG_END_CHAR: cfg_q.end_char <= cfg_wdata;
				REG_DELIM_COUNT: cfg_q.delim_count <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	// The framer packs the frame body into 32-bit words and writes each of the first seven
	// to the RAM bank of the current frame as soon as its fourth byte arrives. The word still
	// being filled, with its zero tail, is handed over with the closed frame.
	dcfd_framer #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.serial(serial),
		.job_ready(job_ready),
		.job(job),
		.ram_wr(ram_wr)
	);

	// Banks alternate per frame, so the next frame fills one bank while the decoder
	// reads the other.
	dcfd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RAM_DEPTH)
	) u_payload_ram (
		.clk(clk),
		.wr_en(ram_wr.en),
		.wr_addr(ram_wr.addr),
		.wr_data(ram_wr.data),
		.rd_en(ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// The decoder reads one word a cycle, takes each word's truncated remainder modulo
	// 123 through a reciprocal multiply, sums the five payload remainders and compares
	// against the sixth word for the add-position command.
	dcfd_decoder u_decoder (
		.clk(clk),
		.arst_n(arst_n),
		.job(job),
		.job_ready(job_ready),
		.ram_rd_en(ram_rd_en),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data),
		.command(command)
	);

endmodule

@@ rtl/dcfd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.

module dcfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/dcfd_framer.sv @@
// Framer: delimiter hunting, end-character replay and word packing into the payload RAM.
// Depends on dcfd_pkg and dcfd_byte_if.

module dcfd_framer #(
	parameter int PAYLOAD_BYTES = dcfd_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dcfd_pkg::cfg_t    cfg,
	dcfd_byte_if.sink         serial,
	input  logic              job_ready,
	output dcfd_pkg::job_t    job,
	output dcfd_pkg::ram_wr_t ram_wr
);
	import dcfd_pkg::*;

	localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int ROW_W = IDX_W - 2;
	localparam logic [IDX_W-1:0] LIMIT = IDX_W'(PAYLOAD_BYTES);

	fr_state_t state_q, state_d;
	logic [1:0] delim_q, delim_d;
	logic [IDX_W-1:0] widx_q, widx_d;
	logic ovf_q, ovf_d;
	logic bank_q, bank_d;
	logic [WORD_W-1:0] lo_q, lo_d;

	logic [2:0] need;
	logic [2:0] delim_inc;
	logic is_start, is_end, closing, accept;
	logic [2:0] cnt, stored, fill_end;
	logic [IDX_W-1:0] room;
	logic hit, complete, row_kept;
	logic [ROW_W-1:0] row;
	logic [2*WORD_W-1:0] win;

	assign need = (cfg.delim_count == 2'd0) ? 3'd1 : {1'b0, cfg.delim_count};
	assign delim_inc = {1'b0, delim_q} + 3'd1;
	assign is_start = serial.in_byte == cfg.start_char;
	assign is_end = serial.in_byte == cfg.end_char;
	assign closing = (state_q == FR_FRAME) && is_end && (delim_inc >= need);

	// A closing byte waits until the decoder can take the frame.
	assign serial.ready = !(closing && !job_ready);
	assign accept = serial.valid && serial.ready;

	// Replayed end characters first, then the byte itself; drop what does not fit.
	assign cnt = {1'b0, delim_q} + 3'd1;
	assign room = LIMIT - widx_q;
	assign hit = IDX_W'(cnt) > room;
	assign stored = hit ? room[2:0] : cnt;
	assign fill_end = {1'b0, widx_q[1:0]} + stored;
	assign complete = fill_end[2];
	assign row = widx_q[IDX_W-1:2];
	assign row_kept = 32'(row) < 32'(NUM_WORDS);

	always_comb begin
		win = {{WORD_W{1'b0}}, lo_q};
		for (int k = 0; k < 3; k++) begin
			if (3'(k) < stored) begin
				win[BYTE_W * (int'(widx_q[1:0]) + k) +: BYTE_W] =
					(3'(k) < {1'b0, delim_q}) ? cfg.end_char : serial.in_byte;
			end
		end
	end

	always_comb begin
		ram_wr.en = accept && (state_q == FR_FRAME) && !is_end && complete && row_kept;
		ram_wr.addr = bank_q ? RAM_AW'(NUM_WORDS) + RAM_AW'(row) : RAM_AW'(row);
		ram_wr.data = win[WORD_W-1:0];
	end

	always_comb begin
		job.valid = accept && closing;
		job.bank = bank_q;
		job.full_words = row_kept ? WORD_IDX_W'(row) : WORD_IDX_W'(NUM_WORDS);
		job.partial = lo_q;
		job.overflow = ovf_q;
	end

	always_comb begin
		state_d = state_q;
		delim_d = delim_q;
		widx_d = widx_q;
		ovf_d = ovf_q;
		bank_d = bank_q;
		lo_d = lo_q;
		if (accept) begin
			case (state_q)
				FR_HUNT: begin
					if (is_start) begin
						if (delim_inc >= need) begin
							state_d = FR_FRAME;
							delim_d = 2'd0;
							widx_d = '0;
							ovf_d = 1'b0;
							lo_d = '0;
							bank_d = !bank_q;
						end else begin
							delim_d = delim_inc[1:0];
						end
					end
				end
				FR_FRAME: begin
					if (!is_end) begin
						delim_d = 2'd0;
						widx_d = widx_q + IDX_W'(stored);
						ovf_d = ovf_q | hit;
						lo_d = complete ? win[2*WORD_W-1:WORD_W] : win[WORD_W-1:0];
					end else if (closing) begin
						state_d = FR_HUNT;
						delim_d = 2'd0;
						widx_d = '0;
					end else begin
						delim_d = delim_inc[1:0];
					end
				end
				default: begin
					state_d = FR_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_HUNT;
			delim_q <= 2'd0;
			widx_q <= '0;
			ovf_q <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			state_q <= state_d;
			delim_q <= delim_d;
			widx_q <= widx_d;
			ovf_q <= ovf_d;
			bank_q <= bank_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
	end

	a_widx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= LIMIT)
		else $error("write index beyond the payload store");

	a_hunt_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_HUNT |-> widx_q == '0)
		else $error("write index not cleared while hunting");

	a_job_taken: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |-> job_ready)
		else $error("frame closed while the decoder was busy");

	a_delim_range: assert property (@(posedge clk) disable iff (!arst_n)
		delim_q != 2'd3)
		else $error("delimiter count held a full set");

endmodule

@@ rtl/dcfd_decoder.sv @@
// Decoder: reads a closed frame's words from the payload RAM, checks the modulo-123 sum
// and holds the result in the output register. Depends on dcfd_pkg and dcfd_result_if.

module dcfd_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dcfd_pkg::job_t               job,
	output logic                         job_ready,
	output logic                         ram_rd_en,
	output logic [dcfd_pkg::RAM_AW-1:0]  ram_rd_addr,
	input  logic [dcfd_pkg::WORD_W-1:0]  ram_rd_data,
	dcfd_result_if.source                command
);
	import dcfd_pkg::*;

	dec_state_t state_q, state_d;
	logic bank_q;
	logic [WORD_IDX_W-1:0] full_q;
	logic [WORD_W-1:0] part_q;
	logic ovf_q;
	logic [WORD_IDX_W-1:0] rd_cnt_q;

	logic v_s1, v_s2, v_s3;
	logic [WORD_IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [WORD_W-1:0] word_s2, mag_s2, mag_s3;
	logic neg_s2, neg_s3;
	logic [2*WORD_W-1:0] prod_s3;

	logic [WORD_W-1:0] words_q [NUM_WORDS];
	logic signed [SUM_W-1:0] sum_q;

	logic issue, load, out_free, check_ok;
	logic [WORD_W-1:0] word_sel;
	logic [QUOT_W-1:0] quot;
	logic [WORD_W-1:0] rem_full;
	logic [REM_W-1:0] srem;

	assign issue = (state_q == D_RUN) && (rd_cnt_q != WORD_IDX_W'(NUM_WORDS));
	assign ram_rd_en = issue;
	assign ram_rd_addr = bank_q ? RAM_AW'(NUM_WORDS) + RAM_AW'(rd_cnt_q) : RAM_AW'(rd_cnt_q);

	// Words past the fill count were never written in this frame and read as zero.
	always_comb begin
		if (idx_s1 < full_q) begin
			word_sel = ram_rd_data;
		end else if (idx_s1 == full_q) begin
			word_sel = part_q;
		end else begin
			word_sel = '0;
		end
	end

	// Truncating remainder: magnitude remainder, then the dividend's sign.
	assign quot = prod_s3[2*WORD_W-1:RECIP_SHIFT];
	assign rem_full = mag_s3 - WORD_W'(quot) * WORD_W'(CHECK_MODULUS);
	assign srem = neg_s3 ? REM_W'(-{1'b0, rem_full[REM_W-2:0]}) : {1'b0, rem_full[REM_W-2:0]};

	assign out_free = !command.valid || command.ready;
	assign check_ok = (words_q[0] != CMD_ADD_POSITION) ||
		({{(WORD_W-SUM_W){sum_q[SUM_W-1]}}, sum_q} == words_q[NUM_WORDS-1]);

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		load = 1'b0;
		case (state_q)
			D_IDLE: begin
				job_ready = 1'b1;
				if (job.valid) begin
					state_d = D_RUN;
				end
			end
			D_RUN: begin
				if (v_s3 && (idx_s3 == LAST_WORD)) begin
					state_d = D_DONE;
				end
			end
			D_DONE: begin
				if (out_free) begin
					load = 1'b1;
					state_d = D_IDLE;
				end
			end
			default: begin
				state_d = D_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rd_cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			command.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (job.valid && job_ready) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load) begin
				command.valid <= 1'b1;
			end else if (command.ready) begin
				command.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && job_ready) begin
			bank_q <= job.bank;
			full_q <= job.full_words;
			part_q <= job.partial;
			ovf_q <= job.overflow;
			sum_q <= '0;
		end else if (v_s3 && (idx_s3 inside {[3'd1:3'd5]})) begin
			sum_q <= sum_q + {{(SUM_W-REM_W){srem[REM_W-1]}}, srem};
		end
		idx_s1 <= rd_cnt_q;

		word_s2 <= word_sel;
		neg_s2 <= word_sel[WORD_W-1];
		mag_s2 <= word_sel[WORD_W-1] ? -word_sel : word_sel;
		idx_s2 <= idx_s1;

		prod_s3 <= mag_s2 * CHECK_RECIP;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		idx_s3 <= idx_s2;
		if (v_s2) begin
			words_q[idx_s2] <= word_s2;
		end

		if (load) begin
			command.command_word <= words_q[0];
			command.recognized <= (words_q[0] >= CMD_FIRST) && (words_q[0] <= CMD_LAST);
			command.accepted <= check_ok;
			command.word_a <= words_q[1];
			command.word_b <= words_q[2];
			command.word_c <= words_q[3];
			command.word_d <= words_q[4];
			command.word_e <= words_q[5];
			command.word_f <= words_q[6];
			command.overflowed <= ovf_q;
		end
	end

	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |-> state_q == D_IDLE)
		else $error("frame handed over while decoding another");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == D_DONE |-> (rd_cnt_q == WORD_IDX_W'(NUM_WORDS)) && !v_s1 && !v_s2 && !v_s3)
		else $error("result finished with words still in flight");

	a_last_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_RUN) && v_s3 && (idx_s3 == LAST_WORD) |=> state_q == D_DONE)
		else $error("last word passed without finishing the result");

endmodule

@@ verif/delimited_command_framer_decoder_core_tb.sv @@
// Self-checking testbench for delimited_command_framer_decoder_core: byte stimulus on the
// serial channel, decoded commands checked against a cycle-free predictor of the framer.
// Depends on dcfd_pkg, dcfd_byte_if, dcfd_result_if and the core itself.

module delimited_command_framer_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcfd_pkg::*;

	localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1400;
	// A settling wait for the core to answer the last closing end character, with ample margin.
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT = 5000;
	localparam int TIMEOUT_NS = 5_000_000;

	// One decoded command as the result channel carries it.
	typedef struct packed {
		logic [WORD_W-1:0] command_word;
		logic recognized;
		logic accepted;
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic [WORD_W-1:0] word_c;
		logic [WORD_W-1:0] word_d;
		logic [WORD_W-1:0] word_e;
		logic [WORD_W-1:0] word_f;
		logic overflowed;
	} command_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dcfd_byte_if serial_bus ();
	dcfd_result_if command_bus ();

	delimited_command_framer_decoder_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.serial(serial_bus),
		.command(command_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the configuration registers.
	logic [BYTE_W-1:0] cfg_start = START_CHAR_RST;
	logic [BYTE_W-1:0] cfg_end = END_CHAR_RST;
	logic [1:0] cfg_delims = DELIM_COUNT_RST;

	// Predictor copy of the framer state.
	bit fr_in_frame = 1'b0;
	int fr_delims = 0;
	int fr_wr_idx = 0;
	bit fr_overflow = 1'b0;
	logic [BYTE_W-1:0] frame_bytes [PAYLOAD_BYTES];

	command_t pending_commands [$];
	int mismatches = 0;
	int frame_items = 0;
	int next_gap = 1;
	bit quiet_phase = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A generous fixed limit; a correct run finishes far inside it.
	initial begin
		#(TIMEOUT_NS);
		$display("delimited_command_framer_decoder_core_tb NOT OK");
		$finish;
	end

	// A delimiter count of zero behaves exactly like a count of one.
	function automatic int delims_needed();
		return (cfg_delims == 2'd0) ? 1 : int'(cfg_delims);
	endfunction

	// Bytes that would run past the end of the store are dropped and remembered.
	function automatic void store_payload_byte(input logic [BYTE_W-1:0] value);
		if (fr_wr_idx < PAYLOAD_BYTES) begin
			frame_bytes[fr_wr_idx] = value;
			fr_wr_idx++;
		end else begin
			fr_overflow = 1'b1;
		end
	endfunction

	// Advances the framer by one accepted byte and queues the command that it closes, if any.
	function automatic void track_serial_byte(input logic [BYTE_W-1:0] value);
		logic [WORD_W-1:0] words [NUM_WORDS];
		longint check_sum;
		command_t cmd;
		int need;
		need = delims_needed();
		if (!fr_in_frame) begin
			// Hunting: only start characters matter, and nothing else clears their count.
			if (value == cfg_start) begin
				fr_delims++;
				if (fr_delims >= need) begin
					fr_in_frame = 1'b1;
					fr_delims = 0;
					fr_wr_idx = 0;
					fr_overflow = 1'b0;
					frame_bytes = '{default: '0};
				end
			end
			return;
		end
		if (value != cfg_end) begin
			// The end characters seen so far were payload after all, so they are replayed.
			repeat (fr_delims) store_payload_byte(cfg_end);
			fr_delims = 0;
			store_payload_byte(value);
			return;
		end
		fr_delims++;
		if (fr_delims < need)
			return;
		for (int w = 0; w < NUM_WORDS; w++)
			words[w] = {frame_bytes[4*w+3], frame_bytes[4*w+2], frame_bytes[4*w+1],
				frame_bytes[4*w]};
		cmd.accepted = 1'b1;
		if (words[0] == CMD_ADD_POSITION) begin
			// Remainders truncate towards zero, so negative words give negative terms.
			check_sum = 0;
			for (int w = 1; w <= 5; w++)
				check_sum += $signed(words[w]) % CHECK_MODULUS;
			cmd.accepted = (check_sum == longint'($signed(words[6])));
		end
		cmd.command_word = words[0];
		cmd.recognized = (words[0] >= CMD_FIRST) && (words[0] <= CMD_LAST);
		cmd.word_a = words[1];
		cmd.word_b = words[2];
		cmd.word_c = words[3];
		cmd.word_d = words[4];
		cmd.word_e = words[5];
		cmd.word_f = words[6];
		cmd.overflowed = fr_overflow;
		pending_commands.push_back(cmd);
		fr_in_frame = 1'b0;
		fr_delims = 0;
		fr_wr_idx = 0;
	endfunction

	// Mostly short gaps, now and then a long one, and none at all in a quiet phase.
	function automatic int pick_gap();
		int roll;
		if (quiet_phase)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic void check_field(input string name, input logic [WORD_W-1:0] expected,
			input logic [WORD_W-1:0] actual);
		if (expected !== actual) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, expected, actual);
			mismatches++;
		end
	endfunction

	// Removes end characters that would close the frame early or merge with the closing run,
	// so that the bytes stored in the core are exactly the ones listed.
	function automatic void clean_delimiters(ref logic [BYTE_W-1:0] body [$], input int need);
		int run;
		run = 0;
		for (int i = 0; i < body.size(); i++) begin
			if (body[i] == cfg_end) begin
				if (run + 1 >= need || i == body.size() - 1) begin
					body[i] = cfg_end ^ 8'h01;
					run = 0;
				end else begin
					run++;
				end
			end else begin
				run = 0;
			end
		end
	endfunction

	// Sends one byte and waits for its transaction. Valid stays high into the next byte when
	// no gap follows, so transactions run back to back.
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		if (next_gap > 0)
			repeat (next_gap) @(posedge clk);
		serial_bus.valid <= 1'b1;
		serial_bus.in_byte <= value;
		@(posedge clk);
		while (!serial_bus.ready)
			@(posedge clk);
		track_serial_byte(value);
		next_gap = pick_gap();
		if (next_gap > 0)
			serial_bus.valid <= 1'b0;
	endtask

	// Waits until every predicted command has arrived and the decoder has had time to finish.
	task automatic wait_idle();
		int waited;
		waited = 0;
		if (next_gap == 0) begin
			serial_bus.valid <= 1'b0;
			next_gap = 1;
		end
		while (pending_commands.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_commands.size() != 0) begin
			$display("%0t ns: outstanding commands mismatch, expected 0 actual %0d", $time,
				pending_commands.size());
			mismatches++;
			pending_commands.delete();
		end
	endtask

	// Writes all three registers on consecutive edges while the core is idle.
	task automatic load_framing(input logic [BYTE_W-1:0] start_value,
			input logic [BYTE_W-1:0] end_value, input logic [1:0] count_value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_START_CHAR;
		cfg_wdata <= start_value;
		@(posedge clk);
		cfg_index <= REG_END_CHAR;
		cfg_wdata <= end_value;
		@(posedge clk);
		cfg_index <= REG_DELIM_COUNT;
		cfg_wdata <= CFG_DATA_W'(count_value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_start = start_value;
		cfg_end = end_value;
		cfg_delims = count_value;
	endtask

	// Builds and sends one frame with random content under the current delimiters. Most frames
	// are well formed; now and then the closing run is left out so the next frame runs on.
	task automatic send_frame();
		logic [BYTE_W-1:0] body [$];
		logic [WORD_W-1:0] cmd;
		logic [WORD_W-1:0] check_word;
		logic [BYTE_W-1:0] noise;
		longint check_sum;
		int need;
		int pick;
		int len;
		need = delims_needed();
		pick = $urandom_range(0, 9);
		if (pick <= 6)
			cmd = WORD_W'(pick);
		else if (pick <= 8)
			cmd = CMD_ADD_POSITION;
		else
			cmd = $urandom();
		if (cmd == CMD_ADD_POSITION && $urandom_range(0, 5) != 0)
			len = 28;
		else if ($urandom_range(0, 7) == 0)
			len = $urandom_range(29, 44);
		else
			len = $urandom_range(0, 28);
		for (int i = 0; i < len; i++) begin
			if (i < 4)
				body.push_back(cmd[8*i +: 8]);
			else if ($urandom_range(0, 5) == 0)
				body.push_back(cfg_end);
			else
				body.push_back(BYTE_W'($urandom()));
		end
		clean_delimiters(body, need);
		if (cmd == CMD_ADD_POSITION && len >= 28) begin
			// Give most add-position frames a matching checksum and spoil the rest.
			check_sum = 0;
			for (int w = 1; w <= 5; w++)
				check_sum += $signed({body[4*w+3], body[4*w+2], body[4*w+1], body[4*w]})
					% CHECK_MODULUS;
			if ($urandom_range(0, 4) == 0)
				check_sum += $urandom_range(1, 3);
			check_word = check_sum[WORD_W-1:0];
			for (int k = 0; k < 4; k++)
				body[24+k] = check_word[8*k +: 8];
			clean_delimiters(body, need);
		end
		// Start characters, with stray bytes between them that must not clear the count.
		for (int s = 0; s < need; s++) begin
			if ($urandom_range(0, 3) == 0) begin
				noise = BYTE_W'($urandom());
				if (noise == cfg_start)
					noise = ~noise;
				send_byte(noise);
			end
			send_byte(cfg_start);
		end
		foreach (body[i])
			send_byte(body[i]);
		if ($urandom_range(0, 11) != 0)
			repeat (need) send_byte(cfg_end);
		frame_items += need * 2 + body.size();
	endtask

	// Reset delimiters, stray bytes at both byte extremes between the start characters, and a
	// short frame whose missing payload must read as zero.
	task automatic test_default_framing();
		send_byte(START_CHAR_RST);
		send_byte(8'h00);
		send_byte(START_CHAR_RST);
		send_byte(8'hFF);
		send_byte(START_CHAR_RST);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		repeat (3) send_byte(END_CHAR_RST);
	endtask

	// A lone end character inside the body is payload and has to be replayed into the store;
	// the command that results is one that the decoder does not know.
	task automatic test_delimiter_replay();
		load_framing(8'hFF, 8'h00, 2'd2);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h05);
		send_byte(8'h00);
		send_byte(8'h07);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	// A delimiter count of zero, then start and end characters that are the same byte, which
	// inside a frame has to close it straight away.
	task automatic test_single_and_shared_delimiters();
		load_framing(8'hFF, 8'h00, 2'd0);
		send_byte(8'hFF);
		send_byte(8'h03);
		send_byte(8'h00);
		load_framing(8'hAA, 8'hAA, 2'd1);
		send_byte(8'hAA);
		send_byte(8'hAA);
	endtask

	// Phases of random frames, each under its own delimiters, with the extremes among them.
	task automatic test_random_traffic();
		logic [BYTE_W-1:0] start_value;
		logic [BYTE_W-1:0] end_value;
		while (frame_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: start_value = 8'h00;
				1: start_value = 8'hFF;
				2: start_value = START_CHAR_RST;
				default: start_value = BYTE_W'($urandom());
			endcase
			case ($urandom_range(0, 5))
				0: end_value = 8'h00;
				1: end_value = 8'hFF;
				2: end_value = END_CHAR_RST;
				default: end_value = BYTE_W'($urandom());
			endcase
			load_framing(start_value, end_value, 2'($urandom_range(0, 3)));
			quiet_phase = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) send_frame();
		end
		quiet_phase = 1'b0;
	endtask

	// The receiver takes commands in bursts of random length with stalls between them.
	initial begin : command_acceptor
		int gap;
		command_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			command_bus.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(100, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 30)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				command_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Every command transaction is checked against the oldest prediction.
	initial begin : command_monitor
		command_t want;
		forever begin
			@(posedge clk);
			if (arst_n && command_bus.valid && command_bus.ready) begin
				if (pending_commands.size() == 0) begin
					$display("%0t ns: unexpected command, expected none actual %h", $time,
						command_bus.command_word);
					mismatches++;
				end else begin
					want = pending_commands.pop_front();
					check_field("command_word", want.command_word, command_bus.command_word);
					check_field("recognized", WORD_W'(want.recognized),
						WORD_W'(command_bus.recognized));
					check_field("accepted", WORD_W'(want.accepted),
						WORD_W'(command_bus.accepted));
					check_field("word_a", want.word_a, command_bus.word_a);
					check_field("word_b", want.word_b, command_bus.word_b);
					check_field("word_c", want.word_c, command_bus.word_c);
					check_field("word_d", want.word_d, command_bus.word_d);
					check_field("word_e", want.word_e, command_bus.word_e);
					check_field("word_f", want.word_f, command_bus.word_f);
					check_field("overflowed", WORD_W'(want.overflowed),
						WORD_W'(command_bus.overflowed));
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_START_CHAR;
		cfg_wdata <= '0;
		serial_bus.valid <= 1'b0;
		serial_bus.in_byte <= '0;
		frame_bytes = '{default: '0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_default_framing();
		test_delimiter_replay();
		test_single_and_shared_delimiters();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0)
			$display("delimited_command_framer_decoder_core_tb OK");
		else
			$display("delimited_command_framer_decoder_core_tb NOT OK");
		$finish;
	end

endmodule

@@ delimited_command_framer_decoder_core.f @@
rtl/dcfd_pkg.sv
rtl/dcfd_byte_if.sv
rtl/dcfd_result_if.sv
rtl/dcfd_ram.sv
rtl/dcfd_framer.sv
rtl/dcfd_decoder.sv
rtl/delimited_command_framer_decoder_core.sv
verif/delimited_command_framer_decoder_core_tb.sv
